// File: design/aqst_pkg.sv
// Package for the asymmetric quantile scale tracker.
// Holds fixed-point constants, register indexes and a saturation helper.
// No dependencies.
`timescale 1ns / 1ps
package aqst_pkg;
  localparam int FracBits = 16;
  localparam int DivW = 32 + FracBits;
  localparam int CntW = $clog2(DivW + 1);
  localparam int LossW = 47;
  localparam logic [LossW-1:0] LossMax = '1;
  localparam logic [63:0] SentWide = 64'd100000000 << FracBits;
  localparam logic [LossW-1:0] Sentinel =
    (SentWide > {{(64-LossW){1'b0}}, LossMax}) ? LossMax : SentWide[LossW-1:0];
  localparam logic [16:0] TauOne = 17'd65536;

  localparam logic [2:0] RegOmegaLo = 3'd0;
  localparam logic [2:0] RegOmegaHi = 3'd1;
  localparam logic [2:0] RegPersist = 3'd2;
  localparam logic [2:0] RegGainRise = 3'd3;
  localparam logic [2:0] RegGainFall = 3'd4;
  localparam logic [2:0] RegLevel = 3'd5;
  localparam logic [2:0] RegStartLo = 3'd6;
  localparam logic [2:0] RegStartHi = 3'd7;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    logic signed [31:0] r;
    if (v > 70'sd2147483647) r = 32'sh7fffffff;
    else if (v < -70'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

// File: design/asymmetric_quantile_scale_tracker.sv
// Top level of the asymmetric quantile scale tracker: sequencer, shared divider
// and shared multiplier. Depends on aqst_pkg.
`timescale 1ns / 1ps
// Channel   | Direction | Content
// s_axis    | in        | tdata: sample[31:0]; tlast: last_sample
// m_axis    | out       | tdata: quant_low, quant_high, forecast_low, forecast_high, loss_total
//           |           | tlast: series_end; tuser: order_fault, scale_fault
// cfg       | in        | write enable, register index, 32-bit data
// Each item is accepted in the idle state, runs through the bit-serial divider and
// the steps of the shared multiplier, then a finish state, and its result is then
// held in the output state until taken. A new sample is accepted only in idle.
// A zero scale skips the divider. Reset clears the tracking state.
// A stalled output holds the block until the result is taken.
module asymmetric_quantile_scale_tracker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,  // sample
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // quant_low, quant_high, forecast_low, forecast_high, loss_total, zero pad
  output logic [175:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  output logic [1:0]   m_axis_tuser_o   // order_fault, scale_fault
);
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_FIN, S_OUT} state_e;
  localparam int F = aqst_pkg::FracBits;
  localparam int DW = aqst_pkg::DivW;
  localparam int LW = aqst_pkg::LossW;

  state_e state_q;
  logic signed [31:0] om_lo_q, om_hi_q, pers_q, g_rise_q, g_fall_q, st_lo_q, st_hi_q;
  logic [16:0] level_q;
  logic signed [31:0] next_lo_q, next_hi_q;
  logic [LW-1:0] acc_q;
  logic at_start_q;
  logic signed [31:0] x_q, ql_q, qh_q;
  logic last_q, first_q, ofault_q, sfault_q;
  logic [DW-1:0] num_q;
  logic [32:0] den_q, rem_q;
  logic [aqst_pkg::CntW-1:0] cnt_q;
  logic [2:0] step_q;
  logic signed [31:0] aeps_q, p_lo_q, p_hi_q, g_lo_q, g_hi_q, a_lo_q, a_hi_q;
  logic [48:0] tl_q, th_q;
  logic signed [31:0] fl_o_q, fh_o_q;
  logic [LW-1:0] loss_o_q;

  logic signed [31:0] ql_in, qh_in, xin, gain;
  logic signed [32:0] scale;
  logic [31:0] xmag;
  logic [33:0] trial;
  logic signed [32:0] el, eh;
  logic [32:0] elm, ehm;
  logic [16:0] tau, ctau;
  logic signed [33:0] op_a, op_b;
  logic signed [67:0] prod;
  logic signed [31:0] mres;
  logic signed [33:0] sum_lo, sum_hi;
  logic [49:0] tsum;
  logic [33:0] add;
  logic [LW-1:0] loss_new;

  always_comb begin
    xin = s_axis_tdata_i;
    ql_in = at_start_q ? st_lo_q : next_lo_q;
    qh_in = at_start_q ? st_hi_q : next_hi_q;
    scale = 33'(qh_in) - 33'(ql_in);
    xmag = xin[31] ? 32'(-33'(xin)) : 32'(xin);
    trial = {rem_q, num_q[DW-1]};
    tau = (level_q > aqst_pkg::TauOne) ? aqst_pkg::TauOne : level_q;
    ctau = aqst_pkg::TauOne - tau;
    el = 33'(x_q) - 33'(ql_q);
    eh = 33'(x_q) - 33'(qh_q);
    elm = el[32] ? -el : el;
    ehm = eh[32] ? -eh : eh;
    gain = (x_q > 0) ? g_rise_q : g_fall_q;
    case (step_q)
      3'd0: begin op_a = 34'(pers_q); op_b = 34'(ql_q); end
      3'd1: begin op_a = 34'(pers_q); op_b = 34'(qh_q); end
      3'd2: begin op_a = 34'(gain); op_b = 34'(ql_q); end
      3'd3: begin op_a = 34'(gain); op_b = 34'(qh_q); end
      3'd4: begin op_a = 34'(g_lo_q); op_b = 34'(aeps_q); end
      3'd5: begin op_a = 34'(g_hi_q); op_b = 34'(aeps_q); end
      3'd6: begin
        op_a = $signed({1'b0, elm});
        op_b = $signed({17'd0, el[32] ? ctau : tau});
      end
      default: begin
        op_a = $signed({1'b0, ehm});
        op_b = $signed({17'd0, eh[32] ? tau : ctau});
      end
    endcase
    prod = op_a * op_b;
    mres = aqst_pkg::sat32(70'(prod >>> F));
    sum_lo = 34'(om_lo_q) + 34'(p_lo_q) + 34'(a_lo_q);
    sum_hi = 34'(om_hi_q) + 34'(p_hi_q) + 34'(a_hi_q);
    tsum = 50'(tl_q) + 50'(th_q);
    add = tsum[49:16];
    if (first_q) loss_new = acc_q;
    else if ({13'd0, add} >= aqst_pkg::LossMax - acc_q) loss_new = aqst_pkg::LossMax;
    else loss_new = acc_q + LW'(add);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      om_lo_q <= '0; om_hi_q <= '0; pers_q <= '0; g_rise_q <= '0; g_fall_q <= '0;
      level_q <= 17'd32768; st_lo_q <= '0; st_hi_q <= 32'sd1 <<< F;
      next_lo_q <= '0; next_hi_q <= '0; acc_q <= '0; at_start_q <= 1'b1;
      cnt_q <= '0; step_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          aqst_pkg::RegOmegaLo: om_lo_q <= cfg_wdata_i;
          aqst_pkg::RegOmegaHi: om_hi_q <= cfg_wdata_i;
          aqst_pkg::RegPersist: pers_q <= cfg_wdata_i;
          aqst_pkg::RegGainRise: g_rise_q <= cfg_wdata_i;
          aqst_pkg::RegGainFall: g_fall_q <= cfg_wdata_i;
          aqst_pkg::RegLevel: level_q <= cfg_wdata_i[16:0];
          aqst_pkg::RegStartLo: st_lo_q <= cfg_wdata_i;
          aqst_pkg::RegStartHi: st_hi_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            x_q <= xin; last_q <= s_axis_tlast_i; first_q <= at_start_q;
            ql_q <= ql_in; qh_q <= qh_in;
            ofault_q <= !(om_lo_q < om_hi_q);
            sfault_q <= (scale == '0);
            num_q <= DW'({xmag, F'(0)});
            den_q <= scale[32] ? 33'(-scale) : 33'(scale);
            rem_q <= '0; cnt_q <= '0; step_q <= '0;
            aeps_q <= 32'sh7fffffff;
            state_q <= (scale == '0) ? S_MUL : S_DIV;
          end
        end
        S_DIV: begin
          if (trial >= {1'b0, den_q}) begin
            rem_q <= 33'(trial - {1'b0, den_q});
            num_q <= {num_q[DW-2:0], 1'b1};
          end else begin
            rem_q <= trial[32:0];
            num_q <= {num_q[DW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == aqst_pkg::CntW'(DW - 1)) state_q <= S_MUL;
        end
        S_MUL: begin
          if (step_q == 3'd0 && !sfault_q)
            aeps_q <= (num_q[DW-1:31] != '0) ? 32'sh7fffffff : $signed(num_q[31:0]);
          case (step_q)
            3'd0: p_lo_q <= mres;
            3'd1: p_hi_q <= mres;
            3'd2: g_lo_q <= mres;
            3'd3: g_hi_q <= mres;
            3'd4: a_lo_q <= mres;
            3'd5: a_hi_q <= mres;
            3'd6: tl_q <= prod[48:0];
            default: th_q <= prod[48:0];
          endcase
          step_q <= step_q + 1'b1;
          if (step_q == 3'd7) state_q <= S_FIN;
        end
        S_FIN: begin
          fl_o_q <= aqst_pkg::sat32(70'(sum_lo));
          fh_o_q <= aqst_pkg::sat32(70'(sum_hi));
          next_lo_q <= aqst_pkg::sat32(70'(sum_lo));
          next_hi_q <= aqst_pkg::sat32(70'(sum_hi));
          loss_o_q <= ofault_q ? aqst_pkg::Sentinel : loss_new;
          acc_q <= last_q ? '0 : loss_new;
          at_start_q <= last_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // aeps is loaded from the registered quotient in num_q on step 0, so step 4 sees it.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o = {1'b0, loss_o_q, fh_o_q, fl_o_q, qh_q, ql_q};
  assign m_axis_tlast_o = last_q;
  assign m_axis_tuser_o = {sfault_q, ofault_q};
endmodule

// File: dv/testbench.sv
// Testbench for the asymmetric quantile scale tracker: random and directed items
// checked against a built-in predictor of the quantile recursion and check loss.
// Depends on aqst_pkg and the asymmetric_quantile_scale_tracker design.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
  } sample_item_t;

  typedef struct packed {
    logic [31:0] q_lo;
    logic [31:0] q_hi;
    logic [31:0] f_lo;
    logic [31:0] f_hi;
    logic [46:0] loss;
    logic        send;
    logic        ofault;
    logic        sfault;
  } track_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_addr_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [175:0] m_axis_tdata_o;
  logic m_axis_tlast_o;
  logic [1:0] m_axis_tuser_o;

  asymmetric_quantile_scale_tracker DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sample_item_t pending_samples[$];
  track_result_t expected_results[$];
  int errors = 0;
  int cycle_count = 0;
  int hold_off = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int accepted_count = 0;
  int seen_count = 0;

  // Predictor copy of registers and tracking state.
  longint om_lo, om_hi, persist, g_rise, g_fall, st_lo, st_hi;
  longint unsigned level;
  longint nxt_lo, nxt_hi;
  longint unsigned loss_acc;
  bit at_start;

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat_word((a * b) >>> aqst_pkg::FracBits);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic void set_register(logic [2:0] idx, logic [31:0] val);
    case (idx)
      aqst_pkg::RegOmegaLo: om_lo = longint'(signed'(val));
      aqst_pkg::RegOmegaHi: om_hi = longint'(signed'(val));
      aqst_pkg::RegPersist: persist = longint'(signed'(val));
      aqst_pkg::RegGainRise: g_rise = longint'(signed'(val));
      aqst_pkg::RegGainFall: g_fall = longint'(signed'(val));
      aqst_pkg::RegLevel: level = val[16:0];
      aqst_pkg::RegStartLo: st_lo = longint'(signed'(val));
      aqst_pkg::RegStartHi: st_hi = longint'(signed'(val));
      default: ;
    endcase
  endfunction

  function automatic track_result_t track_sample(sample_item_t it);
    track_result_t r;
    longint x, ql, qh, scale, aeps, gain, fl, fh, el, eh;
    longint unsigned tau, ctau, quo, tl, th, add;
    x = longint'(signed'(it.sample));
    ql = at_start ? st_lo : nxt_lo;
    qh = at_start ? st_hi : nxt_hi;
    scale = qh - ql;
    tau = level > 65536 ? 65536 : level;
    ctau = 65536 - tau;
    if (scale == 0) aeps = 64'sd2147483647;
    else begin
      quo = (magnitude(x) << aqst_pkg::FracBits) / magnitude(scale);
      aeps = quo > 64'd2147483647 ? 64'sd2147483647 : longint'(quo);
    end
    gain = x > 0 ? g_rise : g_fall;
    fl = sat_word(om_lo + qmul(persist, ql) + qmul(qmul(gain, ql), aeps));
    fh = sat_word(om_hi + qmul(persist, qh) + qmul(qmul(gain, qh), aeps));
    if (!at_start) begin
      el = x - ql;
      eh = x - qh;
      tl = el >= 0 ? longint'(el) * tau : magnitude(el) * ctau;
      th = eh >= 0 ? longint'(eh) * ctau : magnitude(eh) * tau;
      add = (tl + th) >> 16;
      loss_acc = (add >= 64'(aqst_pkg::LossMax) - loss_acc) ? 64'(aqst_pkg::LossMax) :
                 loss_acc + add;
    end
    r.q_lo = ql[31:0];
    r.q_hi = qh[31:0];
    r.f_lo = fl[31:0];
    r.f_hi = fh[31:0];
    r.ofault = !(om_lo < om_hi);
    r.sfault = scale == 0;
    r.loss = r.ofault ? aqst_pkg::Sentinel : loss_acc[46:0];
    r.send = it.last;
    nxt_lo = fl;
    nxt_hi = fh;
    at_start = it.last;
    if (it.last) loss_acc = 0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // Driver: holds an offered item until the monitor has seen it accepted.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (accepted_count != seen_count) begin
        seen_count = accepted_count;
        send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 120) :
                   $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
        s_axis_tvalid_i <= 1'b0;
      end
      if (!s_axis_tvalid_i || accepted_count == seen_count && seen_count != 0 &&
          s_axis_tvalid_i && !s_axis_tready_o && 1'b0) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= pending_samples[0].sample;
          s_axis_tlast_i <= pending_samples[0].last;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end else if (seen_count == accepted_count && pending_samples.size() > 0 &&
                   s_axis_tdata_i === pending_samples[0].sample &&
                   s_axis_tlast_i === pending_samples[0].last) begin
        s_axis_tvalid_i <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= pending_samples[0].sample;
        s_axis_tlast_i <= pending_samples[0].last;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      m_axis_tready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if ($urandom_range(0, 5) == 0)
        recv_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) :
                   $urandom_range(1, 3);
    end
  end

  // Monitor: updates the predictor on each accepted item and checks each result.
  always @(posedge clk_i) begin
    track_result_t want;
    cycle_count++;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      expected_results.push_back(track_sample(pending_samples.pop_front()));
      accepted_count++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata_o[63:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata_o[31:0] !== want.q_lo)
          report_mismatch("quant_low", m_axis_tdata_o[31:0], want.q_lo);
        if (m_axis_tdata_o[63:32] !== want.q_hi)
          report_mismatch("quant_high", m_axis_tdata_o[63:32], want.q_hi);
        if (m_axis_tdata_o[95:64] !== want.f_lo)
          report_mismatch("forecast_low", m_axis_tdata_o[95:64], want.f_lo);
        if (m_axis_tdata_o[127:96] !== want.f_hi)
          report_mismatch("forecast_high", m_axis_tdata_o[127:96], want.f_hi);
        if (m_axis_tdata_o[174:128] !== want.loss)
          report_mismatch("loss_total", m_axis_tdata_o[174:128], want.loss);
        if (m_axis_tlast_o !== want.send)
          report_mismatch("series_end", m_axis_tlast_o, want.send);
        if (m_axis_tuser_o[0] !== want.ofault)
          report_mismatch("order_fault", m_axis_tuser_o[0], want.ofault);
        if (m_axis_tuser_o[1] !== want.sfault)
          report_mismatch("scale_fault", m_axis_tuser_o[1], want.sfault);
      end
    end
    if (cycle_count > 3000000) begin
      $display("asymmetric_quantile_scale_tracker test failed");
      $finish;
    end
  end

  task automatic write_register(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    set_register(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($urandom_range(0, 4)) - 32'd2;
      default: return 32'(signed'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  task automatic push_series(int len);
    sample_item_t it;
    for (int k = 0; k < len; k++) begin
      it.sample = random_sample();
      it.last = (k == len - 1);
      pending_samples.push_back(it);
    end
  endtask

  task automatic random_settings(bit extreme);
    write_register(aqst_pkg::RegOmegaLo,
                   extreme ? $urandom : 32'($urandom_range(0, 8192)) - 32'd8192);
    write_register(aqst_pkg::RegOmegaHi, extreme ? $urandom : 32'($urandom_range(0, 8192)));
    write_register(aqst_pkg::RegPersist,
                   extreme ? $urandom : 32'($urandom_range(45000, 65000)));
    write_register(aqst_pkg::RegGainRise,
                   extreme ? $urandom : 32'($urandom_range(0, 40000)) - 32'd20000);
    write_register(aqst_pkg::RegGainFall,
                   extreme ? $urandom : 32'($urandom_range(0, 40000)) - 32'd20000);
    write_register(aqst_pkg::RegLevel, {15'd0, 17'($urandom_range(0, 131071))});
    write_register(aqst_pkg::RegStartLo,
                   extreme ? $urandom : 32'($urandom_range(0, 65536)) - 32'd65536);
    write_register(aqst_pkg::RegStartHi,
                   extreme ? $urandom : 32'($urandom_range(0, 65536)));
  endtask

  initial begin
    sample_item_t it;
    om_lo = 0; om_hi = 0; persist = 0; g_rise = 0; g_fall = 0;
    level = 32768; st_lo = 0; st_hi = 65536;
    nxt_lo = 0; nxt_hi = 0; loss_acc = 0; at_start = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings give misordered intercepts; then zero scale and extremes.
    it.last = 1'b0;
    it.sample = 32'h7fffffff; pending_samples.push_back(it);
    it.sample = 32'h80000000; pending_samples.push_back(it);
    it.sample = 32'h0; pending_samples.push_back(it);
    it.sample = 32'hffffffff; it.last = 1'b1; pending_samples.push_back(it);
    wait_idle();
    write_register(aqst_pkg::RegOmegaLo, 32'hffff0000);
    write_register(aqst_pkg::RegOmegaHi, 32'h00010000);
    write_register(aqst_pkg::RegPersist, 32'h0000e000);
    write_register(aqst_pkg::RegGainRise, 32'h00002000);
    write_register(aqst_pkg::RegGainFall, 32'hffffc000);
    write_register(aqst_pkg::RegLevel, 32'h00010000);
    write_register(aqst_pkg::RegStartLo, 32'h00008000);
    write_register(aqst_pkg::RegStartHi, 32'h00008000);
    it.last = 1'b0;
    it.sample = 32'h00010000; pending_samples.push_back(it);
    it.sample = 32'hfffe0000; pending_samples.push_back(it);
    it.sample = 32'h7fffffff; pending_samples.push_back(it);
    it.sample = 32'h80000000; pending_samples.push_back(it);
    it.sample = 32'h00000001; it.last = 1'b1; pending_samples.push_back(it);
    wait_idle();
    write_register(aqst_pkg::RegLevel, 32'h0001ffff);
    write_register(aqst_pkg::RegPersist, 32'h7fffffff);
    write_register(aqst_pkg::RegGainRise, 32'h80000000);
    push_series(6);
    wait_idle();
    write_register(aqst_pkg::RegLevel, 32'h0);
    write_register(aqst_pkg::RegPersist, 32'h80000000);
    write_register(aqst_pkg::RegGainFall, 32'h7fffffff);
    push_series(6);
    wait_idle();

    for (int phase = 0; phase < 9; phase++) begin
      random_settings(phase % 4 == 3);
      if (phase == 2) hold_off = 1500;
      for (int s = 0; s < 12; s++) begin
        if ($urandom_range(0, 9) == 0) push_series(1);
        else push_series($urandom_range(2, 24));
      end
      wait_idle();
    end
    if (errors == 0) $display("asymmetric_quantile_scale_tracker test passed");
    else $display("asymmetric_quantile_scale_tracker test failed");
    $finish;
  end
endmodule
